// ===== rtl/core/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// MST engine package
// Shared types and fixed constants of the minimum spanning tree engine.
// ----------------------------------------------------------------------------
package mst_pkg;

    // Depth of the queue that carries sorted edges from the front to the back.
    localparam int FIFO_DEPTH = 4;

    // Fill status of the edge queue, as seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// ===== rtl/core/mst_ifs.sv =====
// ----------------------------------------------------------------------------
// MST engine channel interfaces
// Valid/ready channels for edges in, tree edges out and the register write.
// ----------------------------------------------------------------------------
interface mst_edge_if #(
    parameter int VB = 5,
    parameter int WB = 16
);
    logic                 valid;
    logic                 ready;
    logic [VB-1:0]        edge_src;
    logic [VB-1:0]        edge_dst;
    logic signed [WB-1:0] edge_weight;
    logic                 last_edge;

    modport source (output valid, edge_src, edge_dst, edge_weight, last_edge, input ready);
    modport sink (input valid, edge_src, edge_dst, edge_weight, last_edge, output ready);
endinterface

interface mst_tree_if #(
    parameter int VB = 5,
    parameter int WB = 16,
    parameter int SB = 21
);
    logic                 valid;
    logic                 ready;
    logic [VB-1:0]        tree_src;
    logic [VB-1:0]        tree_dst;
    logic signed [WB-1:0] tree_weight;
    logic signed [SB-1:0] total_weight;
    logic                 last;
    logic                 no_tree_edge;

    modport source (output valid, tree_src, tree_dst, tree_weight, total_weight, last,
                    no_tree_edge, input ready);
    modport sink (input valid, tree_src, tree_dst, tree_weight, total_weight, last,
                  no_tree_edge, output ready);
endinterface

interface mst_cfg_if #(
    parameter int CB = 6
);
    logic          valid;
    logic          ready;
    logic [CB-1:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink (input valid, vertex_count, output ready);
endinterface

// ===== rtl/core/mst_ram.sv =====
// ----------------------------------------------------------------------------
// MST engine RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/core/mst_fifo.sv =====
// ----------------------------------------------------------------------------
// MST engine edge queue
// Small register queue between the sorting front and the union-find back.
// ----------------------------------------------------------------------------
module mst_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   pop_data,
    output mst_pkg::fifo_stat_t stat
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      fill_reg, fill_next;
    logic             do_push, do_pop;

    assign stat.full  = (fill_reg == (PW+1)'(DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== rtl/core/mst_front.sv =====
// ----------------------------------------------------------------------------
// MST engine front
// Loads and filters edges, then emits them in sorted order by repeated scans.
// ----------------------------------------------------------------------------
module mst_front #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    mst_edge_if.sink            edges,
    mst_cfg_if.sink             cfg,
    output logic                push,
    output logic [2*((MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1)+WEIGHT_BITS:0] push_data,
    input  mst_pkg::fifo_stat_t stat
);
    localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int KW = WEIGHT_BITS + 2 * VB;
    localparam int CB = VB + 1;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CB-1:0] vcount_reg;
    logic [EB:0]   count_reg, count_next;
    logic [EB:0]   idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [KW-1:0] prev_reg, prev_next;
    logic          has_prev_reg, has_prev_next;
    logic [KW-1:0] best_reg, best_next;
    logic          has_best_reg, has_best_next;

    logic [CB-1:0] nv;
    logic          accept, keep;
    logic [KW-1:0] in_key, rd_key;
    logic          key_gt, key_lt;

    assign cfg.ready = 1'b1;
    assign edges.ready = (state_reg == ST_LOAD);
    assign accept = edges.valid && edges.ready;
    assign nv = (vcount_reg > CB'(MAX_VERTICES)) ? CB'(MAX_VERTICES) : vcount_reg;
    assign keep = (count_reg < (EB+1)'(MAX_EDGES)) && ({1'b0, edges.edge_src} < nv)
                  && ({1'b0, edges.edge_dst} < nv);

    // Flipping the weight sign bit makes an unsigned compare of the packed key
    // order edges by signed weight, then source, then destination.
    assign in_key = {~edges.edge_weight[WEIGHT_BITS-1], edges.edge_weight[WEIGHT_BITS-2:0],
                     edges.edge_src, edges.edge_dst};

    mst_ram #(.WIDTH(KW), .DEPTH(MAX_EDGES), .AW(EB)) u_edge_ram (
        .clk     (clk),
        .wr_en   (accept && keep),
        .wr_addr (count_reg[EB-1:0]),
        .wr_data (in_key),
        .rd_addr (idx_reg[EB-1:0]),
        .rd_data (rd_key)
    );

    assign key_gt = !has_prev_reg || (rd_key > prev_reg);
    assign key_lt = !has_best_reg || (rd_key < best_reg);

    assign push      = (state_reg == ST_PUSH);
    assign push_data = {!has_best_reg, best_reg};

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        prev_next     = prev_reg;
        has_prev_next = has_prev_reg;
        best_next     = best_reg;
        has_best_next = has_best_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (keep)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (edges.last_edge)
                    begin
                        state_next    = ST_SCAN;
                        idx_next      = '0;
                        has_prev_next = 1'b0;
                        has_best_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg && key_gt && key_lt)
                begin
                    best_next     = rd_key;
                    has_best_next = 1'b1;
                end
                if (idx_reg == count_reg && !pend_reg)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!stat.full)
                begin
                    if (has_best_reg)
                    begin
                        prev_next     = best_reg;
                        has_prev_next = 1'b1;
                        has_best_next = 1'b0;
                        idx_next      = '0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            vcount_reg   <= CB'(32);
            count_reg    <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            has_prev_reg <= 1'b0;
            has_best_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            has_prev_reg <= has_prev_next;
            has_best_reg <= has_best_next;
            if (cfg.valid)
            begin
                vcount_reg <= cfg.vertex_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        best_reg <= best_next;
    end
endmodule

// ===== rtl/core/mst_back.sv =====
// ----------------------------------------------------------------------------
// MST engine back
// Union-find over sorted edges; emits tree edges with a running weight sum.
// ----------------------------------------------------------------------------
module mst_back #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    output logic                pop,
    input  logic [2*((MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1)+WEIGHT_BITS:0] pop_data,
    input  mst_pkg::fifo_stat_t stat,
    mst_tree_if.source          tree
);
    localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int KW = WEIGHT_BITS + 2 * VB;
    localparam int SB = WEIGHT_BITS + EB - 1;
    localparam int PW = VB + 2;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_FU_RD  = 4'd2;
    localparam logic [3:0] ST_FU_CHK = 4'd3;
    localparam logic [3:0] ST_FV_RD  = 4'd4;
    localparam logic [3:0] ST_FV_CHK = 4'd5;
    localparam logic [3:0] ST_MERGE1 = 4'd6;
    localparam logic [3:0] ST_MERGE2 = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;
    localparam logic [3:0] ST_FINISH = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [VB-1:0]        clr_reg, clr_next;
    logic [KW-1:0]        cur_reg, cur_next;
    logic [VB-1:0]        x_reg, x_next;
    logic [VB-1:0]        pu_reg, pu_next;
    logic signed [PW-1:0] su_reg, su_next;
    logic [VB-1:0]        pv_reg, pv_next;
    logic signed [PW-1:0] sv_reg, sv_next;
    logic signed [SB-1:0] sum_reg, sum_next;
    logic                 hold_vld_reg, hold_vld_next;
    logic [KW-1:0]        hold_key_reg, hold_key_next;
    logic signed [SB-1:0] hold_sum_reg, hold_sum_next;
    logic                 out_vld_reg, out_vld_next;
    logic [KW-1:0]        out_key_reg, out_key_next;
    logic signed [SB-1:0] out_sum_reg, out_sum_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_none_reg, out_none_next;

    logic                 wr_en;
    logic [VB-1:0]        wr_addr;
    logic signed [PW-1:0] wr_data;
    logic signed [PW-1:0] rd_data;
    logic                 out_free;
    logic signed [WEIGHT_BITS-1:0] cur_w;
    logic signed [SB-1:0]          cur_wx;

    mst_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES), .AW(VB)) u_set_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (x_reg),
        .rd_data (rd_data)
    );

    assign cur_w    = {~cur_reg[KW-1], cur_reg[KW-2:2*VB]};
    assign cur_wx   = SB'(cur_w);
    assign out_free = !out_vld_reg || tree.ready;
    assign pop      = (state_reg == ST_IDLE) && !stat.empty;

    assign tree.valid        = out_vld_reg;
    assign tree.tree_src     = out_none_reg ? '0 : out_key_reg[2*VB-1:VB];
    assign tree.tree_dst     = out_none_reg ? '0 : out_key_reg[VB-1:0];
    assign tree.tree_weight  = out_none_reg ? '0 :
                               {~out_key_reg[KW-1], out_key_reg[KW-2:2*VB]};
    assign tree.total_weight = out_none_reg ? '0 : out_sum_reg;
    assign tree.last         = out_last_reg;
    assign tree.no_tree_edge = out_none_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cur_next      = cur_reg;
        x_next        = x_reg;
        pu_next       = pu_reg;
        su_next       = su_reg;
        pv_next       = pv_reg;
        sv_next       = sv_reg;
        sum_next      = sum_reg;
        hold_vld_next = hold_vld_reg;
        hold_key_next = hold_key_reg;
        hold_sum_next = hold_sum_reg;
        out_vld_next  = out_vld_reg && !tree.ready;
        out_key_next  = out_key_reg;
        out_sum_next  = out_sum_reg;
        out_last_next = out_last_reg;
        out_none_next = out_none_reg;
        wr_en         = 1'b0;
        wr_addr       = clr_reg;
        wr_data       = -PW'(1);
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == VB'(MAX_VERTICES - 1))
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!stat.empty)
                begin
                    if (pop_data[KW])
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cur_next   = pop_data[KW-1:0];
                        x_next     = pop_data[2*VB-1:VB];
                        state_next = ST_FU_RD;
                    end
                end
            end
            ST_FU_RD:
            begin
                state_next = ST_FU_CHK;
            end
            ST_FU_CHK:
            begin
                if (!rd_data[PW-1])
                begin
                    x_next     = rd_data[VB-1:0];
                    state_next = ST_FU_RD;
                end
                else
                begin
                    pu_next    = x_reg;
                    su_next    = rd_data;
                    x_next     = cur_reg[VB-1:0];
                    state_next = ST_FV_RD;
                end
            end
            ST_FV_RD:
            begin
                state_next = ST_FV_CHK;
            end
            ST_FV_CHK:
            begin
                if (!rd_data[PW-1])
                begin
                    x_next     = rd_data[VB-1:0];
                    state_next = ST_FV_RD;
                end
                else
                begin
                    pv_next    = x_reg;
                    sv_next    = rd_data;
                    state_next = (x_reg == pu_reg) ? ST_IDLE : ST_MERGE1;
                end
            end
            ST_MERGE1:
            begin
                // The larger set keeps its root; on a tie the destination wins.
                wr_en      = 1'b1;
                wr_data    = su_reg + sv_reg;
                wr_addr    = (su_reg < sv_reg) ? pu_reg : pv_reg;
                state_next = ST_MERGE2;
            end
            ST_MERGE2:
            begin
                wr_en      = 1'b1;
                wr_addr    = (su_reg < sv_reg) ? pv_reg : pu_reg;
                wr_data    = (su_reg < sv_reg) ? PW'({2'b00, pu_reg}) : PW'({2'b00, pv_reg});
                sum_next   = sum_reg + cur_wx;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // One tree edge is held back so the final one can carry last.
                if (!hold_vld_reg || out_free)
                begin
                    if (hold_vld_reg)
                    begin
                        out_vld_next  = 1'b1;
                        out_key_next  = hold_key_reg;
                        out_sum_next  = hold_sum_reg;
                        out_last_next = 1'b0;
                        out_none_next = 1'b0;
                    end
                    hold_vld_next = 1'b1;
                    hold_key_next = cur_reg;
                    hold_sum_next = sum_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_key_next  = hold_key_reg;
                    out_sum_next  = hold_sum_reg;
                    out_last_next = 1'b1;
                    out_none_next = !hold_vld_reg;
                    hold_vld_next = 1'b0;
                    sum_next      = '0;
                    state_next    = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            sum_reg      <= '0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            sum_reg      <= sum_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        x_reg        <= x_next;
        pu_reg       <= pu_next;
        su_reg       <= su_next;
        pv_reg       <= pv_next;
        sv_reg       <= sv_next;
        hold_key_reg <= hold_key_next;
        hold_sum_reg <= hold_sum_next;
        out_key_reg  <= out_key_next;
        out_sum_reg  <= out_sum_next;
        out_last_reg <= out_last_next;
        out_none_reg <= out_none_next;
    end
endmodule

// ===== rtl/core/minimum_spanning_tree_engine.sv =====
// ----------------------------------------------------------------------------
// Minimum spanning tree engine
// Kruskal's algorithm: edge load, sort by repeated scans, union-find merging.
// ----------------------------------------------------------------------------
// Edges load at one request per cycle while the front is in its load state;
// it takes none while it scans or pushes. After the last edge, sorting scans
// the stored edges repeatedly, each scan finding the next larger key.
// The union-find back reads and then checks each step of each root walk,
// and overlaps with sorting through a four-entry queue.
// Reset clears all control state; the back then sets every vertex to a root
// and repeats that pass after every run.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_engine #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input logic        clk,
    input logic        rst_n,
    mst_edge_if.sink   edges,
    mst_cfg_if.sink    cfg,
    mst_tree_if.source tree
);
    localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int KW = WEIGHT_BITS + 2 * VB;

    // Queue entries carry a packed sort key and an end-of-run marker on top.
    logic                push;
    logic [KW:0]         push_data;
    logic                pop;
    logic [KW:0]         pop_data;
    mst_pkg::fifo_stat_t stat;

    // The front stores requests, then finds the next larger key on each scan.
    // Identical edges collapse into one, which never changes the tree chosen.
    mst_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .edges     (edges),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data),
        .stat      (stat)
    );

    mst_fifo #(
        .WIDTH (KW + 1),
        .DEPTH (mst_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (stat)
    );

    // The back walks the forest in its RAM and drives the result register.
    mst_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .pop_data (pop_data),
        .stat     (stat),
        .tree     (tree)
    );
endmodule
